FILE: src/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: src/rpn_pkg.sv
// -----------------------------------------------------------------------------
// rpn_pkg
// Types and codes shared by the stack calculator.
// -----------------------------------------------------------------------------
package rpn_pkg;
	typedef enum logic [3:0] {
		OP_PUSH = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3, OP_DIV = 4'd4,
		OP_POP = 4'd5, OP_PEEK = 4'd6, OP_DUP = 4'd7, OP_SWAP = 4'd8, OP_CLEAR = 4'd9
	} op_t;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_ZDIV    = 3'd3;
	localparam logic [2:0] ST_SWAP    = 3'd4;
	localparam logic [2:0] ST_UNKNOWN = 3'd5;

	typedef struct packed {
		logic [3:0]         func;
		logic signed [31:0] operand;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               value_valid;
		logic [2:0]         status;
		logic [7:0]         depth;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RD1, S_RD2, S_EXEC, S_MUL, S_DIVW, S_WR2, S_OUT
	} state_t;

	typedef struct packed {
		logic               start;
		logic               neg;
		logic [47:0]        num;
		logic [31:0]        den;
	} div_req_t;
endpackage

FILE: src/rpn_stack_calculator.sv
// -----------------------------------------------------------------------------
// rpn_stack_calculator
// RPN calculator over Q16.16 values with a stack held in a synchronous RAM.
// -----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries {func, operand}; output channel
// out_valid/out_ready carries {result_value, value_valid, status, depth}.
// Each accepted item gives exactly one result item.
// One item at a time: after the input transfer come two RAM reads, then
// execute; multiply adds a registered product stage, swap a second
// write-back and divide a wait for the bit-serial divider. The next item is
// taken once the controller is back in idle after the output step.
// A waiting result does not block the input: the next item is taken and runs
// up to its execute step, where it waits until the output register is free;
// in_ready stays low meanwhile. Reset clears the stack pointer (empty stack),
// the control state and the output valid flag; the RAM contents need no
// clearing.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"
module rpn_stack_calculator #(
	parameter int STACK_DEPTH = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rpn_pkg::in_item_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rpn_pkg::out_item_t   out_data
);
	import rpn_pkg::*;

	localparam int AW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
	localparam int PW = $clog2(STACK_DEPTH + 1);
	localparam logic [PW-1:0] FULL = PW'(STACK_DEPTH);

	logic signed [31:0] mem [STACK_DEPTH];
	logic [AW-1:0]      raddr;
	logic signed [31:0] rdata;
	logic               we;
	logic [AW-1:0]      waddr;
	logic signed [31:0] wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

	state_t state_q, state_d;
	logic [PW-1:0]      sp_q;
	in_item_t           item_q;
	logic signed [31:0] a_q, b_q;
	logic signed [63:0] prod_q;
	out_item_t          res_q;
	logic               out_full_q;
	div_req_t           dreq;
	logic               ddone;
	logic signed [31:0] dquot;

	rpn_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .quot(dquot));

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_full_q;
	assign out_data  = res_q;

	logic [PW-1:0] sp_next;
	logic          fin;
	out_item_t     res_d;
	logic          wr2;

	function automatic logic signed [31:0] clamp(input logic signed [63:0] v);
		if (v > 64'sh7fffffff) return 32'sh7fffffff;
		if (v < -64'sh80000000) return 32'sh80000000;
		return v[31:0];
	endfunction

	logic [PW-1:0] n_have;
	logic          has1, has2;
	logic signed [32:0] sum;
	logic signed [31:0] ua, ub;
	assign has1 = sp_q >= PW'(1);
	assign has2 = sp_q >= PW'(2);
	assign ua   = has2 ? a_q : 32'sd0;
	assign ub   = has1 ? b_q : 32'sd0;
	assign n_have = has2 ? sp_q - PW'(2) : '0;

	always_comb begin
		state_d = state_q;
		raddr   = AW'(sp_q - PW'(1));
		we      = 1'b0;
		waddr   = AW'(sp_q);
		wdata   = item_q.operand;
		sp_next = sp_q;
		fin     = 1'b0;
		res_d   = '{result_value: 32'sd0, value_valid: 1'b0, status: ST_OK, depth: 8'd0};
		dreq    = '{start: 1'b0, neg: a_q[31] ^ b_q[31],
			num: {16'd0, (a_q[31] ? 32'(-a_q) : a_q)} << 16,
			den: b_q[31] ? 32'(-b_q) : b_q};
		sum     = '0;
		wr2     = 1'b0;
		unique case (state_q)
			S_IDLE: if (in_valid && in_ready) state_d = S_RD1;
			S_RD1: begin
				raddr   = AW'(sp_q - PW'(2));
				state_d = S_RD2;
			end
			S_RD2: state_d = S_EXEC;
			S_EXEC: begin
				if (out_full_q && !out_ready) begin
					state_d = S_EXEC;
				end else begin
					state_d = S_OUT;
					fin     = 1'b1;
					unique case (item_q.func)
						OP_PUSH: begin
							if (sp_q < FULL) begin
								we = 1'b1;
								sp_next = sp_q + PW'(1);
							end else res_d.status = ST_FULL;
						end
						OP_ADD, OP_SUB: begin
							sum = (item_q.func == OP_ADD) ? 33'(ua) + 33'(ub) : 33'(ua) - 33'(ub);
							if (!has2) res_d.status = ST_EMPTY;
							we = 1'b1;
							waddr = AW'(n_have);
							wdata = clamp(64'(sum));
							sp_next = n_have + PW'(1);
						end
						OP_MUL: begin
							fin = 1'b0;
							state_d = S_MUL;
						end
						OP_DIV: begin
							if (!has1) res_d.status = ST_EMPTY;
							else if (b_q == 0) begin
								res_d.status = ST_ZDIV;
								sp_next = sp_q - PW'(1);
							end else if (!has2) begin
								res_d.status = ST_EMPTY;
								we = 1'b1;
								waddr = '0;
								wdata = 32'sd0;
								sp_next = PW'(1);
							end else begin
								fin = 1'b0;
								dreq.start = 1'b1;
								state_d = S_DIVW;
							end
						end
						OP_POP: begin
							if (has1) begin
								res_d.result_value = b_q;
								res_d.value_valid = 1'b1;
								sp_next = sp_q - PW'(1);
							end else res_d.status = ST_EMPTY;
						end
						OP_PEEK, OP_DUP: begin
							if (has1) begin
								res_d.result_value = b_q;
								res_d.value_valid = 1'b1;
								if (item_q.func == OP_DUP) begin
									if (sp_q < FULL) begin
										we = 1'b1;
										wdata = b_q;
										sp_next = sp_q + PW'(1);
									end else res_d.status = ST_FULL;
								end
							end else res_d.status = ST_EMPTY;
						end
						OP_SWAP: begin
							if (has2) begin
								we = 1'b1;
								waddr = AW'(sp_q - PW'(1));
								wdata = a_q;
								fin = 1'b0;
								state_d = S_WR2;
							end else res_d.status = ST_SWAP;
						end
						OP_CLEAR: begin
							if (has1) begin
								res_d.result_value = 32'(sp_q);
								res_d.value_valid = 1'b1;
								sp_next = '0;
							end else res_d.status = ST_EMPTY;
						end
						default: res_d.status = ST_UNKNOWN;
					endcase
				end
			end
			S_MUL: begin
				if (!has2) res_d.status = ST_EMPTY;
				we = 1'b1;
				waddr = AW'(n_have);
				wdata = clamp(prod_q >>> 16);
				sp_next = n_have + PW'(1);
				fin = 1'b1;
				state_d = S_OUT;
			end
			S_DIVW: begin
				if (ddone) begin
					we = 1'b1;
					waddr = AW'(n_have);
					wdata = dquot;
					sp_next = n_have + PW'(1);
					fin = 1'b1;
					state_d = S_OUT;
				end
			end
			S_WR2: begin
				wr2 = 1'b1;
				we = 1'b1;
				waddr = AW'(sp_q - PW'(2));
				wdata = b_q;
				fin = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		res_d.depth = 8'(sp_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			sp_q       <= '0;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sp_q    <= sp_next;
			if (fin) out_full_q <= 1'b1;
			else if (out_ready) out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_q <= in_data;
		if (state_q == S_RD1) b_q <= rdata;
		if (state_q == S_RD2) a_q <= rdata;
		if (state_q == S_EXEC) prod_q <= 64'(ua) * 64'(ub);
		if (fin) res_q <= res_d;
	end

	`ASSERT_CLK(a_sp_range, clk, arst_n, sp_q <= FULL)
	`ASSERT_CLK(a_fin_empty, clk, arst_n, fin |-> (!out_full_q || out_ready))
	`ASSERT_CLK(a_in_idle, clk, arst_n, (in_valid && in_ready) |=> (state_q == S_RD1))
	`ASSERT_CLK(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> $stable(out_data))
	`ASSERT_CLK(a_swap_two, clk, arst_n, wr2 |-> has2)
endmodule

FILE: src/rpn_divider.sv
// -----------------------------------------------------------------------------
// rpn_divider
// Restoring unsigned divider, one quotient bit per cycle, signed fixup and clamp.
// -----------------------------------------------------------------------------
module rpn_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  rpn_pkg::div_req_t  req,
	output logic               done,
	output logic signed [31:0] quot
);
	import rpn_pkg::*;

	logic [47:0] q_q;
	logic [32:0] r_q;
	logic [31:0] d_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;
	logic [33:0] sub;

	assign trial = {r_q[31:0], q_q[47]};
	assign sub   = {1'b0, trial} - {2'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd48;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q   <= req.num;
			d_q   <= req.den;
			r_q   <= '0;
			neg_q <= req.neg;
		end else if (busy_q) begin
			if (!sub[33]) begin
				r_q <= sub[32:0];
				q_q <= {q_q[46:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[46:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (neg_q) begin
			quot = (q_q > 48'h80000000) ? 32'sh80000000 : 32'(-q_q);
		end else begin
			quot = (q_q > 48'h7fffffff) ? 32'sh7fffffff : 32'(q_q);
		end
	end
endmodule

FILE: tb/sv/testbench.sv
// -----------------------------------------------------------------------------
// testbench
// Drives random and directed opcode streams into the RPN stack calculator with
// random idling on both channels and checks every result against a predictor.
// -----------------------------------------------------------------------------
import rpn_pkg::*;

class rpn_scoreboard;
	logic signed [31:0] stk [128];
	int unsigned sp;
	out_item_t pending [$];
	int errors;

	function new();
		sp = 0;
		errors = 0;
	endfunction

	function automatic logic signed [31:0] sat(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic bit pop1(output logic signed [31:0] v);
		if (sp > 0) begin
			sp--;
			v = stk[sp];
			return 1;
		end
		v = 0;
		return 0;
	endfunction

	function automatic bit push1(logic signed [31:0] v);
		if (sp < 128) begin
			stk[sp] = v;
			sp++;
			return 1;
		end
		return 0;
	endfunction

	function void note_input(in_item_t it);
		out_item_t r;
		logic signed [31:0] a, b, t;
		bit oa, ob;
		longint p, q;
		r = '0;
		r.status = ST_OK;
		case (it.func)
			OP_PUSH: if (!push1(it.operand)) r.status = ST_FULL;
			OP_ADD, OP_SUB, OP_MUL: begin
				ob = pop1(b);
				oa = pop1(a);
				if (!oa || !ob) r.status = ST_EMPTY;
				if (it.func == OP_ADD) void'(push1(sat(longint'(a) + longint'(b))));
				else if (it.func == OP_SUB) void'(push1(sat(longint'(a) - longint'(b))));
				else begin
					p = longint'(a) * longint'(b);
					q = p >>> 16;
					void'(push1(sat(q)));
				end
			end
			OP_DIV: begin
				ob = pop1(b);
				if (!ob) r.status = ST_EMPTY;
				else if (b == 0) r.status = ST_ZDIV;
				else begin
					oa = pop1(a);
					if (!oa) r.status = ST_EMPTY;
					void'(push1(sat((longint'(a) * 65536) / longint'(b))));
				end
			end
			OP_POP: begin
				if (pop1(a)) begin
					r.result_value = a;
					r.value_valid = 1;
				end else r.status = ST_EMPTY;
			end
			OP_PEEK, OP_DUP: begin
				if (sp > 0) begin
					r.result_value = stk[sp-1];
					r.value_valid = 1;
					if (it.func == OP_DUP && !push1(stk[sp-1])) r.status = ST_FULL;
				end else r.status = ST_EMPTY;
			end
			OP_SWAP: begin
				if (sp > 1) begin
					t = stk[sp-1];
					stk[sp-1] = stk[sp-2];
					stk[sp-2] = t;
				end else r.status = ST_SWAP;
			end
			OP_CLEAR: begin
				if (sp > 0) begin
					r.result_value = sp;
					r.value_valid = 1;
					sp = 0;
				end else r.status = ST_EMPTY;
			end
			default: r.status = ST_UNKNOWN;
		endcase
		r.depth = sp[7:0];
		pending.push_back(r);
	endfunction

	function void check_result(out_item_t got);
		out_item_t e;
		if (pending.size() == 0) begin
			$display("%0t unexpected result %h", $time, got);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.result_value !== e.result_value)
			$display("%0t result_value exp %h act %h", $time, e.result_value, got.result_value);
		if (got.value_valid !== e.value_valid)
			$display("%0t value_valid exp %b act %b", $time, e.value_valid, got.value_valid);
		if (got.status !== e.status)
			$display("%0t status exp %0d act %0d", $time, e.status, got.status);
		if (got.depth !== e.depth)
			$display("%0t depth exp %0d act %0d", $time, e.depth, got.depth);
		if (got !== e) errors++;
	endfunction
endclass

module testbench;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	out_item_t out_data;

	rpn_scoreboard sb;
	int unsigned quiet = 0;
	bit calm = 0;

	localparam int WATCHDOG = 2000;

	rpn_stack_calculator u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial sb = new();

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_input(in_data);
			if (out_valid && out_ready) sb.check_result(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
			else quiet <= quiet + 1;
			if (quiet >= WATCHDOG) begin
				$display("status: fail");
				$finish;
			end
			out_ready <= calm || ($urandom_range(99) >= 32);
		end
	end

	function automatic logic signed [31:0] rand_val();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 0;
			3: return $signed($urandom_range(32'h3ffff)) - 32'sh20000;
			default: return $urandom;
		endcase
	endfunction

	task automatic send(logic [3:0] f, logic signed [31:0] v);
		while (!calm && $urandom_range(99) < 32) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= {f, v};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	initial begin
		int i, n;
		logic [3:0] f;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send(OP_POP, 0);
		send(OP_PEEK, 0);
		send(OP_CLEAR, 0);
		send(OP_SWAP, 0);
		send(OP_DIV, 0);
		send(OP_ADD, 0);
		send(OP_PUSH, 32'sh7fffffff);
		send(OP_SWAP, 0);
		send(OP_PUSH, 32'sh7fffffff);
		send(OP_ADD, 0);
		send(OP_PUSH, 32'sh80000000);
		send(OP_MUL, 0);
		send(OP_PUSH, 32'sh80000000);
		send(OP_SUB, 0);
		send(OP_PUSH, 0);
		send(OP_DIV, 0);
		send(OP_PUSH, -32'sd3);
		send(OP_DIV, 0);
		send(OP_DUP, 0);
		send(OP_SWAP, 0);
		send(OP_PEEK, 0);
		send(4'd15, 32'shffffffff);
		send(4'd10, 0);
		send(OP_CLEAR, 0);
		for (i = 0; i < 129; i++) send(OP_PUSH, rand_val());
		send(OP_DUP, 0);
		send(OP_CLEAR, 0);
		for (i = 0; i < 800; i++) begin
			calm = (i >= 400 && i < 500);
			n = $urandom_range(99);
			if (n < 35) f = OP_PUSH;
			else if (n < 60) f = 4'($urandom_range(OP_ADD, OP_DIV));
			else if (n < 92) f = 4'($urandom_range(OP_POP, OP_SWAP));
			else if (n < 96) f = OP_CLEAR;
			else f = 4'($urandom_range(10, 15));
			if (f == OP_DIV && $urandom_range(9) == 0) f = OP_SUB;
			send(f, rand_val());
		end
		in_valid <= 0;
		calm = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule

FILE: rpn_stack_calculator.f
+incdir+src
src/rpn_pkg.sv
src/rpn_divider.sv
src/rpn_stack_calculator.sv
tb/sv/testbench.sv
